### hdl/bag_sensing_event_controller_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bag sensing event controller
// Checks run in simulation and drop out of the synthesized netlist.
// ----------------------------------------------------------------------------
`ifndef BAG_SENSING_EVENT_CONTROLLER_MACROS_SVH
`define BAG_SENSING_EVENT_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define BSEC_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication
`define BSEC_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define BSEC_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg)
`define BSEC_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

### hdl/bsec_pkg.sv
// ----------------------------------------------------------------------------
// bsec_pkg
// Shared types and constants of the bag sensing event controller.
// ----------------------------------------------------------------------------
package bsec_pkg;

  // Ledger geometry
  localparam int MAX_OBJECTS    = 16;
  localparam int CAPTURE_FRAMES = 4;
  localparam int LEDGER_AW      = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int LEDGER_CW      = $clog2(MAX_OBJECTS + 1);

  // Field widths
  localparam int DATA_W  = 32;
  localparam int ID_W    = 16;
  localparam int CNT8_W  = 8;
  localparam int CFG16_W = 16;

  // Register reset values
  localparam logic [CFG16_W-1:0] DEBOUNCE_RST = 16'd40;
  localparam logic [CFG16_W-1:0] SETTLE_RST   = 16'd2000;
  localparam logic [CFG16_W-1:0] CAPTURE_RST  = 16'd400;
  localparam logic [DATA_W-1:0]  STALE_RST    = 32'd1200;

  // Request codes
  typedef enum logic [2:0] {
    REQ_OPENED     = 3'd0,
    REQ_CLOSED     = 3'd1,
    REQ_TOF        = 3'd2,
    REQ_FRAME      = 3'd3,
    REQ_CLASSIFIED = 3'd4,
    REQ_MOTION     = 3'd5,
    REQ_STILL      = 3'd6,
    REQ_TICK       = 3'd7
  } req_t;

  // Power modes
  typedef enum logic [1:0] {
    MODE_SLEEP   = 2'd0,
    MODE_OPEN    = 2'd1,
    MODE_CAPTURE = 2'd2,
    MODE_SETTLE  = 2'd3
  } mode_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_SETTLE   = 2'd1,
    CFG_CAPTURE  = 2'd2,
    CFG_STALE    = 2'd3
  } cfg_idx_t;

  // Sequencer to ledger
  typedef struct packed {
    logic                 start;
    logic                 wr_en;
    logic                 append;
    logic [LEDGER_AW-1:0] wr_idx;
    logic                 wr_pres;
    logic [ID_W-1:0]      id;
  } lgr_cmd_t;

  // Ledger to sequencer
  typedef struct packed {
    logic                 done;
    logic                 found;
    logic [LEDGER_AW-1:0] found_idx;
    logic                 found_pres;
    logic [CNT8_W-1:0]    used;
  } lgr_sts_t;

endpackage

### hdl/bsec_if.sv
// ----------------------------------------------------------------------------
// bsec channel interfaces
// Valid/ready channels for event items and result items.
// ----------------------------------------------------------------------------
interface bsec_in_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          req_type;
  logic [bsec_pkg::DATA_W-1:0]         event_time;
  logic signed [bsec_pkg::DATA_W-1:0]  event_arg;
  logic                                entering;

  modport source (output valid, req_type, event_time, event_arg, entering, input ready);
  modport sink   (input valid, req_type, event_time, event_arg, entering, output ready);
endinterface

interface bsec_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        fsm_state;
  logic                              map_stale;
  logic                              object_held;
  logic [bsec_pkg::CNT8_W-1:0]       frame_count;
  logic [bsec_pkg::DATA_W-1:0]       burst_count;
  logic [bsec_pkg::DATA_W-1:0]       measure_count;
  logic [bsec_pkg::DATA_W-1:0]       bounce_count;
  logic [bsec_pkg::DATA_W-1:0]       ledger_sequence;
  logic [bsec_pkg::CNT8_W-1:0]       ledger_entries;

  modport source (output valid, fsm_state, map_stale, object_held, frame_count, burst_count,
                  measure_count, bounce_count, ledger_sequence, ledger_entries,
                  input ready);
  modport sink   (input valid, fsm_state, map_stale, object_held, frame_count, burst_count,
                  measure_count, bounce_count, ledger_sequence, ledger_entries,
                  output ready);
endinterface

### hdl/bag_sensing_event_controller.sv
// ----------------------------------------------------------------------------
// bag_sensing_event_controller
// Event-driven power sequencer: closure debounce, capture bursts, presence
// ledger and settle/measure control, one result item per event item.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Handshake          | Payload
//  ---------+-----+--------------------+----------------------------------------
//  in_chan  | in  | valid/ready        | req_type, event_time, event_arg, entering
//  out_chan | out | valid/ready        | fsm_state .. ledger_entries
//  cfg_*    | in  | cfg_we, no backoff | cfg_index, cfg_wdata
//
//  An item first runs the ledger search, which reads one slot per cycle;
//  then the shared adder runs the time difference, the threshold compare
//  and the staleness compare in turn.
//  in_chan.ready is high only while idle; a finished result waits in the
//  output register and the next item is taken meanwhile.
//  Reset is synchronous and active low; there is no clearing pass.
//
`include "bag_sensing_event_controller_macros.svh"

module bag_sensing_event_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  bsec_in_if.sink                       in_chan,
  bsec_out_if.source                    out_chan,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bsec_pkg::DATA_W-1:0]   cfg_wdata
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_DIFF  = 7'b0000100,
    ST_CMP   = 7'b0001000,
    ST_APPLY = 7'b0010000,
    ST_STALE = 7'b0100000,
    ST_OUT   = 7'b1000000
  } st_t;

  st_t                             st_r, st_nxt;

  // Latched item
  bsec_pkg::req_t                  req_r;
  logic [bsec_pkg::DATA_W-1:0]     time_r;
  logic [bsec_pkg::DATA_W-1:0]     arg_r;
  logic                            ent_r;

  // Configuration
  logic [bsec_pkg::CFG16_W-1:0]    debounce_r;
  logic [bsec_pkg::CFG16_W-1:0]    settle_r;
  logic [bsec_pkg::CFG16_W-1:0]    capture_r;
  logic [bsec_pkg::DATA_W-1:0]     stale_thr_r;

  // Controller state
  bsec_pkg::mode_t                 mode_r, mode_nxt;
  logic [bsec_pkg::DATA_W-1:0]     since_r, since_nxt;
  logic                            edge_seen_r, edge_seen_nxt;
  logic [bsec_pkg::DATA_W-1:0]     last_edge_r, last_edge_nxt;
  logic [bsec_pkg::DATA_W-1:0]     rejected_r, rejected_nxt;
  logic [bsec_pkg::CNT8_W-1:0]     frames_r, frames_nxt;
  logic [bsec_pkg::DATA_W-1:0]     bursts_r, bursts_nxt;
  logic [bsec_pkg::DATA_W-1:0]     measures_r, measures_nxt;
  logic                            map_valid_r, map_valid_nxt;
  logic [bsec_pkg::DATA_W-1:0]     dist_r, dist_nxt;
  logic [bsec_pkg::DATA_W-1:0]     seq_r, seq_nxt;

  // Work registers
  logic [bsec_pkg::DATA_W-1:0]     diff_r;
  logic                            dcarry_r;
  logic                            cmp_r;
  logic                            held_r, held_nxt;
  logic                            stale_r;

  // Output register
  logic                            out_valid_r;
  logic [1:0]                      o_state_r;
  logic                            o_stale_r;
  logic                            o_held_r;
  logic [bsec_pkg::CNT8_W-1:0]     o_frames_r;
  logic [bsec_pkg::DATA_W-1:0]     o_bursts_r;
  logic [bsec_pkg::DATA_W-1:0]     o_measures_r;
  logic [bsec_pkg::DATA_W-1:0]     o_rejected_r;
  logic [bsec_pkg::DATA_W-1:0]     o_seq_r;
  logic [bsec_pkg::CNT8_W-1:0]     o_used_r;

  // Shared adder
  logic [bsec_pkg::DATA_W-1:0]     alu_a, alu_b, alu_sum;
  logic                            alu_sub, alu_cin, alu_carry;

  bsec_pkg::lgr_cmd_t              lgr_cmd;
  bsec_pkg::lgr_sts_t              lgr_sts;

  logic                            accept;
  logic                            out_free;
  logic                            load;
  logic                            is_edge;
  logic                            room;
  logic                            append_ok;
  logic                            frames_open;

  assign accept      = in_chan.valid && in_chan.ready;
  assign out_free    = !out_valid_r || out_chan.ready;
  assign load        = (st_r == ST_OUT) && out_free;
  assign is_edge     = (req_r == bsec_pkg::REQ_OPENED) || (req_r == bsec_pkg::REQ_CLOSED);
  assign room        = lgr_sts.used < bsec_pkg::CNT8_W'(bsec_pkg::MAX_OBJECTS);
  assign append_ok   = !lgr_sts.found && ent_r && room;
  assign frames_open = frames_r < bsec_pkg::CNT8_W'(bsec_pkg::CAPTURE_FRAMES);

  bsec_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .cin   (alu_cin),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  bsec_ledger u_ledger (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (lgr_cmd),
    .sts   (lgr_sts)
  );

  // Select adder operands for the current step
  always_comb begin
    alu_a   = diff_r;
    alu_b   = '0;
    alu_sub = 1'b1;
    alu_cin = 1'b1;
    case (st_r)
      ST_DIFF: begin
        if (req_r == bsec_pkg::REQ_MOTION) begin
          alu_a   = dist_r;
          alu_b   = arg_r;
          alu_sub = 1'b0;
          alu_cin = 1'b0;
        end else begin
          alu_a = time_r;
          alu_b = is_edge ? last_edge_r : since_r;
        end
      end
      ST_CMP: begin
        alu_a = diff_r;
        if (is_edge) begin
          alu_b = bsec_pkg::DATA_W'(debounce_r);
        end else if (req_r == bsec_pkg::REQ_TICK && mode_r == bsec_pkg::MODE_CAPTURE) begin
          alu_b   = bsec_pkg::DATA_W'(capture_r);
          alu_cin = 1'b0;
        end else begin
          alu_b = bsec_pkg::DATA_W'(settle_r);
        end
      end
      ST_STALE: begin
        alu_a = dist_r;
        alu_b = stale_thr_r;
      end
      default: begin
        alu_a = diff_r;
      end
    endcase
  end

  // Sequencer and state update
  always_comb begin
    st_nxt        = st_r;
    mode_nxt      = mode_r;
    since_nxt     = since_r;
    edge_seen_nxt = edge_seen_r;
    last_edge_nxt = last_edge_r;
    rejected_nxt  = rejected_r;
    frames_nxt    = frames_r;
    bursts_nxt    = bursts_r;
    measures_nxt  = measures_r;
    map_valid_nxt = map_valid_r;
    dist_nxt      = dist_r;
    seq_nxt       = seq_r;
    held_nxt      = held_r;

    lgr_cmd         = '0;
    lgr_cmd.id      = arg_r[bsec_pkg::ID_W-1:0];
    lgr_cmd.wr_pres = ent_r;

    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          lgr_cmd.start = 1'b1;
          st_nxt        = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (lgr_sts.done) begin
          st_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        st_nxt = ST_CMP;
      end
      ST_CMP: begin
        st_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        st_nxt   = ST_STALE;
        held_nxt = lgr_sts.found && lgr_sts.found_pres;
        case (req_r)
          bsec_pkg::REQ_OPENED, bsec_pkg::REQ_CLOSED: begin
            if (edge_seen_r && !cmp_r) begin
              rejected_nxt = rejected_r + 1'b1;
            end else begin
              edge_seen_nxt = 1'b1;
              last_edge_nxt = time_r;
              if (req_r == bsec_pkg::REQ_OPENED) begin
                if (mode_r == bsec_pkg::MODE_SLEEP || mode_r == bsec_pkg::MODE_SETTLE) begin
                  mode_nxt  = bsec_pkg::MODE_OPEN;
                  since_nxt = time_r;
                end
              end else begin
                mode_nxt   = bsec_pkg::MODE_SLEEP;
                since_nxt  = time_r;
                frames_nxt = '0;
              end
            end
          end
          bsec_pkg::REQ_TOF: begin
            if (mode_r == bsec_pkg::MODE_OPEN) begin
              mode_nxt   = bsec_pkg::MODE_CAPTURE;
              since_nxt  = time_r;
              frames_nxt = '0;
              bursts_nxt = bursts_r + 1'b1;
            end
          end
          bsec_pkg::REQ_FRAME: begin
            if (mode_r == bsec_pkg::MODE_CAPTURE && frames_open) begin
              frames_nxt = frames_r + 1'b1;
            end
          end
          bsec_pkg::REQ_CLASSIFIED: begin
            if (mode_r == bsec_pkg::MODE_CAPTURE) begin
              // Mark a known slot, or append a new one while room remains
              if (lgr_sts.found || append_ok) begin
                lgr_cmd.wr_en  = 1'b1;
                lgr_cmd.append = append_ok;
                lgr_cmd.wr_idx = lgr_sts.found ? lgr_sts.found_idx
                                               : lgr_sts.used[bsec_pkg::LEDGER_AW-1:0];
                seq_nxt        = seq_r + 1'b1;
              end
              held_nxt      = (lgr_sts.found || append_ok) && ent_r;
              map_valid_nxt = 1'b0;
              dist_nxt      = stale_thr_r;
              mode_nxt      = bsec_pkg::MODE_SETTLE;
              since_nxt     = time_r;
            end
          end
          bsec_pkg::REQ_MOTION: begin
            // Saturating add of a positive amount
            if (arg_r != '0 && !arg_r[bsec_pkg::DATA_W-1]) begin
              dist_nxt = dcarry_r ? '1 : diff_r;
            end
            if (mode_r == bsec_pkg::MODE_SETTLE) begin
              since_nxt = time_r;
            end
          end
          bsec_pkg::REQ_STILL: begin
            if (mode_r == bsec_pkg::MODE_SETTLE && cmp_r) begin
              measures_nxt  = measures_r + 1'b1;
              dist_nxt      = '0;
              map_valid_nxt = 1'b1;
              mode_nxt      = bsec_pkg::MODE_SLEEP;
              since_nxt     = time_r;
            end
          end
          bsec_pkg::REQ_TICK: begin
            if (mode_r == bsec_pkg::MODE_CAPTURE) begin
              if (frames_open && cmp_r) begin
                mode_nxt  = bsec_pkg::MODE_OPEN;
                since_nxt = time_r;
              end
            end else if (mode_r == bsec_pkg::MODE_SETTLE && cmp_r) begin
              measures_nxt  = measures_r + 1'b1;
              dist_nxt      = '0;
              map_valid_nxt = 1'b1;
              mode_nxt      = bsec_pkg::MODE_SLEEP;
              since_nxt     = time_r;
            end
          end
          default: begin
            held_nxt = lgr_sts.found && lgr_sts.found_pres;
          end
        endcase
      end
      ST_STALE: begin
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      mode_r      <= bsec_pkg::MODE_SLEEP;
      since_r     <= '0;
      edge_seen_r <= 1'b0;
      last_edge_r <= '0;
      rejected_r  <= '0;
      frames_r    <= '0;
      bursts_r    <= '0;
      measures_r  <= '0;
      map_valid_r <= 1'b0;
      dist_r      <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      mode_r      <= mode_nxt;
      since_r     <= since_nxt;
      edge_seen_r <= edge_seen_nxt;
      last_edge_r <= last_edge_nxt;
      rejected_r  <= rejected_nxt;
      frames_r    <= frames_nxt;
      bursts_r    <= bursts_nxt;
      measures_r  <= measures_nxt;
      map_valid_r <= map_valid_nxt;
      dist_r      <= dist_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= (out_valid_r && !out_chan.ready) || load;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= bsec_pkg::DEBOUNCE_RST;
      settle_r    <= bsec_pkg::SETTLE_RST;
      capture_r   <= bsec_pkg::CAPTURE_RST;
      stale_thr_r <= bsec_pkg::STALE_RST;
    end else if (cfg_we) begin
      case (bsec_pkg::cfg_idx_t'(cfg_index))
        bsec_pkg::CFG_DEBOUNCE: debounce_r  <= cfg_wdata[bsec_pkg::CFG16_W-1:0];
        bsec_pkg::CFG_SETTLE:   settle_r    <= cfg_wdata[bsec_pkg::CFG16_W-1:0];
        bsec_pkg::CFG_CAPTURE:  capture_r   <= cfg_wdata[bsec_pkg::CFG16_W-1:0];
        bsec_pkg::CFG_STALE:    stale_thr_r <= cfg_wdata;
        default: begin
          stale_thr_r <= stale_thr_r;
        end
      endcase
    end
  end

  // Item latch and adder results
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= bsec_pkg::req_t'(in_chan.req_type);
      time_r <= in_chan.event_time;
      arg_r  <= in_chan.event_arg;
      ent_r  <= in_chan.entering;
    end
    if (st_r == ST_DIFF) begin
      diff_r   <= alu_sum;
      dcarry_r <= alu_carry;
    end
    if (st_r == ST_CMP) begin
      cmp_r <= alu_carry;
    end
    if (st_r == ST_APPLY) begin
      held_r <= held_nxt;
    end
    if (st_r == ST_STALE) begin
      stale_r <= !map_valid_r || alu_carry;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      o_state_r    <= mode_r;
      o_stale_r    <= stale_r;
      o_held_r     <= held_r;
      o_frames_r   <= frames_r;
      o_bursts_r   <= bursts_r;
      o_measures_r <= measures_r;
      o_rejected_r <= rejected_r;
      o_seq_r      <= seq_r;
      o_used_r     <= lgr_sts.used;
    end
  end

  assign in_chan.ready            = (st_r == ST_IDLE);
  assign out_chan.valid           = out_valid_r;
  assign out_chan.fsm_state       = o_state_r;
  assign out_chan.map_stale       = o_stale_r;
  assign out_chan.object_held     = o_held_r;
  assign out_chan.frame_count     = o_frames_r;
  assign out_chan.burst_count     = o_bursts_r;
  assign out_chan.measure_count   = o_measures_r;
  assign out_chan.bounce_count    = o_rejected_r;
  assign out_chan.ledger_sequence = o_seq_r;
  assign out_chan.ledger_entries  = o_used_r;

  // Checks
  `BSEC_ASSERT_NXT(a_accept_scan, clk, rst_n, accept, st_r == ST_SCAN, "no search after accept")
  `BSEC_ASSERT_NXT(a_seq_step, clk, rst_n, lgr_cmd.wr_en, seq_r == $past(seq_r) + 32'd1, "no seq step")
  `BSEC_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, lgr_sts.used <= bsec_pkg::CNT8_W'(bsec_pkg::MAX_OBJECTS), "overfull")

endmodule

### hdl/bsec_alu.sv
// ----------------------------------------------------------------------------
// bsec_alu
// Shared 32-bit add/subtract unit with carry out, used for every time
// difference, threshold compare and disturbance sum.
// ----------------------------------------------------------------------------
module bsec_alu (
  input  logic [bsec_pkg::DATA_W-1:0] a,
  input  logic [bsec_pkg::DATA_W-1:0] b,
  input  logic                        sub,
  input  logic                        cin,
  output logic [bsec_pkg::DATA_W-1:0] sum,
  output logic                        carry
);

  logic [bsec_pkg::DATA_W-1:0] b_op;
  logic [bsec_pkg::DATA_W:0]   total;

  // Invert b for subtract; carry set means a >= b (cin 1) or a > b (cin 0)
  assign b_op  = sub ? ~b : b;
  assign total = {1'b0, a} + {1'b0, b_op} + {{bsec_pkg::DATA_W{1'b0}}, cin};
  assign sum   = total[bsec_pkg::DATA_W-1:0];
  assign carry = total[bsec_pkg::DATA_W];

endmodule

### hdl/bsec_ledger.sv
// ----------------------------------------------------------------------------
// bsec_ledger
// Presence ledger: slot memory, slot count and a linear search that
// compares one slot per cycle against the requested id.
// ----------------------------------------------------------------------------
module bsec_ledger (
  input  logic                clk,
  input  logic                rst_n,
  input  bsec_pkg::lgr_cmd_t  cmd,
  output bsec_pkg::lgr_sts_t  sts
);

  logic [bsec_pkg::ID_W-1:0]      ids_mem  [bsec_pkg::MAX_OBJECTS];
  logic                           pres_mem [bsec_pkg::MAX_OBJECTS];

  logic                           scan_r;
  logic [bsec_pkg::LEDGER_CW-1:0] idx_r;
  logic                           cmp_vld_r;
  logic [bsec_pkg::ID_W-1:0]      rd_id_r;
  logic                           rd_pres_r;
  logic [bsec_pkg::LEDGER_AW-1:0] rd_idx_r;
  logic                           found_r;
  logic [bsec_pkg::LEDGER_AW-1:0] found_idx_r;
  logic                           found_pres_r;
  logic [bsec_pkg::CNT8_W-1:0]    used_r;

  logic                           issue;
  logic                           done;
  logic                           hit;

  // Issue one slot read per cycle while below the fill count
  assign issue = scan_r && (bsec_pkg::CNT8_W'(idx_r) < used_r);
  assign done  = scan_r && !issue && !cmp_vld_r;
  assign hit   = cmp_vld_r && (rd_id_r == cmd.id) && !found_r;

  // Sequence the search and count slots in use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r    <= 1'b0;
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
      used_r    <= '0;
    end else begin
      if (cmd.start) begin
        scan_r    <= 1'b1;
        idx_r     <= '0;
        cmp_vld_r <= 1'b0;
        found_r   <= 1'b0;
      end else if (scan_r) begin
        cmp_vld_r <= issue;
        if (issue) begin
          idx_r <= idx_r + 1'b1;
        end
        if (hit) begin
          found_r <= 1'b1;
        end
        if (done) begin
          scan_r <= 1'b0;
        end
      end
      if (cmd.wr_en && cmd.append) begin
        used_r <= used_r + 1'b1;
      end
    end
  end

  // Capture the matching slot
  always_ff @(posedge clk) begin
    if (hit) begin
      found_idx_r  <= rd_idx_r;
      found_pres_r <= rd_pres_r;
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_id_r   <= ids_mem[idx_r[bsec_pkg::LEDGER_AW-1:0]];
      rd_pres_r <= pres_mem[idx_r[bsec_pkg::LEDGER_AW-1:0]];
      rd_idx_r  <= idx_r[bsec_pkg::LEDGER_AW-1:0];
    end
    if (cmd.wr_en) begin
      ids_mem[cmd.wr_idx]  <= cmd.id;
      pres_mem[cmd.wr_idx] <= cmd.wr_pres;
    end
  end

  assign sts.done       = done;
  assign sts.found      = found_r;
  assign sts.found_idx  = found_idx_r;
  assign sts.found_pres = found_pres_r;
  assign sts.used       = used_r;

endmodule

### dv/bsec_sb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsec_sb_pkg
// Event and status item types, plus the status scoreboard of the controller
// bench. The scoreboard keeps its own sequencer state and ledger, works out
// the status that each accepted event must produce, and checks the results
// in order.
// ----------------------------------------------------------------------------
package bsec_sb_pkg;
  import bsec_pkg::*;

  typedef struct {
    req_t        kind;
    logic [31:0] t_ms;
    logic [31:0] arg;
    logic        entering;
  } event_item_t;

  typedef struct {
    logic [1:0]  state;
    logic        stale;
    logic        held;
    logic [7:0]  frames;
    logic [31:0] bursts;
    logic [31:0] measures;
    logic [31:0] bounces;
    logic [31:0] ledger_seq;
    logic [7:0]  entries;
  } status_t;

  class bsec_scoreboard;
    // Register copies
    logic [15:0] debounce_ms;
    logic [15:0] settle_lim;
    logic [15:0] capture_ms;
    logic [31:0] stale_level;

    // Sequencer state
    mode_t       mode;
    logic [31:0] mode_t0;
    logic        edge_seen;
    logic [31:0] last_edge;
    logic [31:0] bounces;
    logic [7:0]  frames;
    logic [31:0] bursts;
    logic [31:0] measures;
    logic        map_ok;
    logic [31:0] disturbance;

    // Presence ledger
    logic [15:0] slot_id [MAX_OBJECTS];
    logic        slot_on [MAX_OBJECTS];
    int unsigned slots_used;
    logic [31:0] ledger_seq;

    status_t     status_due [$];
    int unsigned errors;

    function new();
      debounce_ms = DEBOUNCE_RST;
      settle_lim  = SETTLE_RST;
      capture_ms  = CAPTURE_RST;
      stale_level = STALE_RST;
      mode        = MODE_SLEEP;
      mode_t0     = '0;
      edge_seen   = 1'b0;
      last_edge   = '0;
      bounces     = '0;
      frames      = '0;
      bursts      = '0;
      measures    = '0;
      map_ok      = 1'b0;
      disturbance = '0;
      slots_used  = 0;
      ledger_seq  = '0;
      errors      = 0;
      for (int i = 0; i < MAX_OBJECTS; i++) begin
        slot_id[i] = '0;
        slot_on[i] = 1'b0;
      end
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] val);
      case (idx)
        CFG_DEBOUNCE: debounce_ms = val[15:0];
        CFG_SETTLE:   settle_lim  = val[15:0];
        CFG_CAPTURE:  capture_ms  = val[15:0];
        CFG_STALE:    stale_level = val;
      endcase
    endfunction

    function int unsigned outstanding();
      return status_due.size();
    endfunction

    function void switch_mode(mode_t m, logic [31:0] t_ms);
      mode    = m;
      mode_t0 = t_ms;
    endfunction

    function int find_slot(logic [15:0] id);
      for (int i = 0; i < slots_used && i < MAX_OBJECTS; i++)
        if (slot_id[i] == id) return i;
      return -1;
    endfunction

    // Append a new id, or mark a known one; unknown leavers and a full
    // ledger change nothing
    function void ledger_update(logic [15:0] id, logic in_flag);
      int s;
      s = find_slot(id);
      if (s < 0) begin
        if (!in_flag || slots_used >= MAX_OBJECTS) return;
        s = slots_used;
        slots_used++;
        slot_id[s] = id;
      end
      slot_on[s] = in_flag;
      ledger_seq++;
    endfunction

    function void finish_measure(logic [31:0] t_ms);
      measures++;
      disturbance = '0;
      map_ok      = 1'b1;
      switch_mode(MODE_SLEEP, t_ms);
    endfunction

    // Apply one accepted event and queue the status it must produce
    function void note_event(event_item_t ev);
      logic [31:0] dt;
      logic [32:0] sum;
      int          s;
      status_t     want;
      dt = ev.t_ms - mode_t0;
      case (ev.kind)
        REQ_OPENED, REQ_CLOSED: begin
          dt = ev.t_ms - last_edge;
          if (edge_seen && dt < {16'd0, debounce_ms}) begin
            bounces++;
          end else begin
            edge_seen = 1'b1;
            last_edge = ev.t_ms;
            if (ev.kind == REQ_OPENED) begin
              if (mode == MODE_SLEEP || mode == MODE_SETTLE) switch_mode(MODE_OPEN, ev.t_ms);
            end else begin
              switch_mode(MODE_SLEEP, ev.t_ms);
              frames = '0;
            end
          end
        end
        REQ_TOF: begin
          if (mode == MODE_OPEN) begin
            switch_mode(MODE_CAPTURE, ev.t_ms);
            frames = '0;
            bursts++;
          end
        end
        REQ_FRAME: begin
          if (mode == MODE_CAPTURE && frames < CAPTURE_FRAMES) frames++;
        end
        REQ_CLASSIFIED: begin
          if (mode == MODE_CAPTURE) begin
            ledger_update(ev.arg[15:0], ev.entering);
            map_ok      = 1'b0;
            disturbance = stale_level;
            switch_mode(MODE_SETTLE, ev.t_ms);
          end
        end
        REQ_MOTION: begin
          // Positive amounts only, saturating
          if (ev.arg != '0 && !ev.arg[31]) begin
            sum = {1'b0, disturbance} + {1'b0, ev.arg};
            disturbance = sum[32] ? '1 : sum[31:0];
          end
          if (mode == MODE_SETTLE) mode_t0 = ev.t_ms;
        end
        REQ_STILL: begin
          if (mode == MODE_SETTLE && dt >= {16'd0, settle_lim}) finish_measure(ev.t_ms);
        end
        REQ_TICK: begin
          if (mode == MODE_CAPTURE) begin
            if (frames < CAPTURE_FRAMES && dt > {16'd0, capture_ms})
              switch_mode(MODE_OPEN, ev.t_ms);
          end else if (mode == MODE_SETTLE) begin
            if (dt >= {16'd0, settle_lim}) finish_measure(ev.t_ms);
          end
        end
      endcase

      // Status after the event; the query id is looked up for every kind
      s = find_slot(ev.arg[15:0]);
      want.state      = mode;
      want.stale      = !map_ok || disturbance >= stale_level;
      want.held       = (s >= 0) ? slot_on[s] : 1'b0;
      want.frames     = frames;
      want.bursts     = bursts;
      want.measures   = measures;
      want.bounces    = bounces;
      want.ledger_seq = ledger_seq;
      want.entries    = 8'(slots_used);
      status_due.push_back(want);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    // Check one result item against the oldest queued status
    function void check_status(status_t got);
      status_t want;
      if (status_due.size() == 0) begin
        $error("result item with no event pending");
        errors++;
        return;
      end
      want = status_due.pop_front();
      compare("fsm_state", 32'(want.state), 32'(got.state));
      compare("map_stale", 32'(want.stale), 32'(got.stale));
      compare("object_held", 32'(want.held), 32'(got.held));
      compare("frame_count", 32'(want.frames), 32'(got.frames));
      compare("burst_count", want.bursts, got.bursts);
      compare("measure_count", want.measures, got.measures);
      compare("bounce_count", want.bounces, got.bounces);
      compare("ledger_sequence", want.ledger_seq, got.ledger_seq);
      compare("ledger_entries", 32'(want.entries), 32'(got.entries));
    endfunction
  endclass

endpackage

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Bench for the bag sensing event controller. A directed run walks the
// debounce, capture, ledger and settle paths, then randomized phases under
// several register settings drive bag open/capture/classify/settle cycles
// mixed with noise, with random stalls on both channels. Every result item
// is checked field by field by the status scoreboard.
// ----------------------------------------------------------------------------
module tb;
  import bsec_pkg::*;
  import bsec_sb_pkg::*;

  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 60;
  localparam int          PHASES       = 8;
  localparam int          PHASE_ITEMS  = 240;
  localparam int          POOL_SIZE    = 24;
  localparam longint      CYCLE_LIMIT  = 1_500_000;

  typedef struct {
    logic [31:0] debounce;
    logic [31:0] settle;
    logic [31:0] capture;
    logic [31:0] stale;
  } reg_set_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  bsec_in_if  in_ch ();
  bsec_out_if out_ch ();

  bag_sensing_event_controller u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bsec_scoreboard sb;
  logic [31:0]    now_ms;
  logic [15:0]    id_pool [POOL_SIZE];
  int unsigned    pool_span;
  int unsigned    events_sent;
  bit             steady;
  bit             hold_req;
  longint         cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Idle length: mostly short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Time step around a register value: below, at, just past, or far off
  function automatic logic [31:0] step_ms(logic [31:0] lim);
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1, 2:    return lim;
      3:       return lim - 32'd1;
      4:       return lim + 32'd1;
      5:       return $urandom;
      6, 7:    return $urandom_range(0, 30);
      default: return $urandom_range(0, lim * 2 + 10);
    endcase
  endfunction

  function automatic logic [31:0] later(logic [31:0] lim);
    now_ms = now_ms + step_ms(lim);
    return now_ms;
  endfunction

  // Random argument; half the time the low half is a known id
  function automatic logic [31:0] query_arg();
    logic [31:0] a;
    a = $urandom;
    if (coin()) a[15:0] = id_pool[$urandom_range(0, pool_span - 1)];
    return a;
  endfunction

  function automatic logic [31:0] class_arg();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(0, 9) != 0) a[15:0] = id_pool[$urandom_range(0, pool_span - 1)];
    return a;
  endfunction

  function automatic logic [31:0] motion_arg();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'h8000_0000 | $urandom;
      2:       return $urandom_range(1, 600);
      3:       return 32'h7FFF_FFFF;
      default: return $urandom & 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pad16(logic [15:0] v);
    logic [15:0] hi;
    hi = coin() ? 16'($urandom) : 16'h0;
    return {hi, v};
  endfunction

  // Offer one event item, hold it until accepted, then maybe idle
  task automatic send_ev(req_t kind, logic [31:0] t_ms, logic [31:0] arg, logic ent);
    event_item_t ev;
    ev.kind     = kind;
    ev.t_ms     = t_ms;
    ev.arg      = arg;
    ev.entering = ent;
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= kind;
    in_ch.event_time <= t_ms;
    in_ch.event_arg  <= arg;
    in_ch.entering   <= ent;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_event(ev);
    events_sent++;
    if (!steady && coin()) begin
      in_ch.valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every expected result, then let the block idle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic program_regs(reg_set_t rs);
    put_reg(CFG_DEBOUNCE, rs.debounce);
    put_reg(CFG_SETTLE, rs.settle);
    put_reg(CFG_CAPTURE, rs.capture);
    put_reg(CFG_STALE, rs.stale);
    cfg_we <= 1'b0;
  endtask

  task automatic directed_ev(req_t kind, logic [31:0] t_ms);
    send_ev(kind, t_ms, query_arg(), coin());
  endtask

  // Directed walk under reset register values
  task automatic directed_run();
    directed_ev(REQ_TICK, 32'd0);
    // first closure edge passes even at the top of the time range
    send_ev(REQ_CLOSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // wrapped 10 ms later: bounced
    send_ev(REQ_OPENED, 32'd9, 32'h8000_0000, 1'b0);
    directed_ev(REQ_OPENED, 32'd39);
    // opened again while open: mode kept
    directed_ev(REQ_OPENED, 32'd100);
    // wrong-mode events are ignored
    directed_ev(REQ_STILL, 32'd110);
    directed_ev(REQ_FRAME, 32'd120);
    directed_ev(REQ_CLASSIFIED, 32'd130);
    directed_ev(REQ_TOF, 32'd200);
    directed_ev(REQ_TOF, 32'd210);
    // frame count stops at the limit
    for (int i = 0; i < 5; i++) directed_ev(REQ_FRAME, 32'd220 + 32'(i * 10));
    // full capture does not time out
    directed_ev(REQ_TICK, 32'd700);
    directed_ev(REQ_CLOSED, 32'd710);
    directed_ev(REQ_OPENED, 32'd800);
    directed_ev(REQ_TOF, 32'd900);
    // timeout only strictly past the limit
    directed_ev(REQ_TICK, 32'd1300);
    directed_ev(REQ_TICK, 32'd1301);
    directed_ev(REQ_TOF, 32'd1400);
    // unknown id leaving: ledger unchanged, still settles
    send_ev(REQ_CLASSIFIED, 32'd1450, 32'hA5A5_1234, 1'b0);
    // saturate disturbance, then a negative amount restarts the timer only
    send_ev(REQ_MOTION, 32'd1500, 32'h7FFF_FFFF, 1'b0);
    send_ev(REQ_MOTION, 32'd1550, 32'h7FFF_FFFF, 1'b1);
    send_ev(REQ_MOTION, 32'd1600, 32'hFFFF_FFFB, 1'b0);
    directed_ev(REQ_STILL, 32'd3599);
    directed_ev(REQ_STILL, 32'd3600);
    now_ms = 32'd3600;
  endtask

  // One bag cycle: open, capture, classify, disturb, settle, maybe close
  task automatic bag_cycle();
    int n;
    n = 0;
    while (sb.mode != MODE_OPEN && n < 3) begin
      send_ev(REQ_OPENED, later(sb.debounce_ms), query_arg(), coin());
      n++;
    end
    // closure chatter
    if ($urandom_range(0, 3) == 0) begin
      send_ev(coin() ? REQ_CLOSED : REQ_OPENED, later(sb.debounce_ms), query_arg(), coin());
      if (sb.mode != MODE_OPEN)
        send_ev(REQ_OPENED, later(sb.debounce_ms), query_arg(), coin());
    end
    send_ev(REQ_TOF, later(100), query_arg(), coin());
    repeat ($urandom_range(0, 6)) send_ev(REQ_FRAME, later(40), query_arg(), coin());
    // capture timeout probe, then retry the crossing
    if ($urandom_range(0, 2) == 0) begin
      send_ev(REQ_TICK, later(sb.capture_ms), query_arg(), coin());
      if (sb.mode == MODE_OPEN) send_ev(REQ_TOF, later(20), query_arg(), coin());
    end
    send_ev(REQ_CLASSIFIED, later(sb.capture_ms / 2), class_arg(),
            $urandom_range(0, 3) != 0);
    repeat ($urandom_range(0, 3))
      send_ev(REQ_MOTION, later(sb.settle_lim / 2), motion_arg(), coin());
    n = 0;
    while (sb.mode == MODE_SETTLE && n < 3) begin
      send_ev(coin() ? REQ_STILL : REQ_TICK, later(sb.settle_lim), query_arg(), coin());
      n++;
    end
    if ($urandom_range(0, 2) == 0)
      send_ev(REQ_CLOSED, later(sb.debounce_ms), query_arg(), coin());
  endtask

  // A few events of any kind, sometimes with a jump in time
  task automatic noise_burst();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 3) == 0) now_ms = $urandom;
      send_ev(req_t'($urandom_range(0, 7)), later(sb.settle_lim), query_arg(), coin());
    end
  endtask

  // One phase: a long receiver hold-off, a full pause, a stretch without idling
  task automatic run_phase(int unsigned stop_at);
    int unsigned hold_at;
    int unsigned pause_at;
    int unsigned calm_at;
    bit          held;
    bit          paused;
    hold_at  = events_sent + $urandom_range(20, 120);
    pause_at = events_sent + $urandom_range(130, 200);
    calm_at  = events_sent + $urandom_range(0, 180);
    held     = 1'b0;
    paused   = 1'b0;
    while (events_sent < stop_at) begin
      if (!held && events_sent >= hold_at) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (!paused && events_sent >= pause_at) begin
        drain_results();
        paused = 1'b1;
      end
      steady = (events_sent >= calm_at && events_sent < calm_at + 30);
      if ($urandom_range(0, 4) == 0) noise_burst();
      else bag_cycle();
    end
    steady = 1'b0;
  endtask

  function automatic reg_set_t pick_regs(int phase);
    reg_set_t rs;
    case (phase)
      1: begin
        rs.debounce = pad16(16'd0);
        rs.settle   = pad16(16'd0);
        rs.capture  = pad16(16'd0);
        rs.stale    = 32'd0;
      end
      2: begin
        rs.debounce = pad16(16'hFFFF);
        rs.settle   = pad16(16'hFFFF);
        rs.capture  = pad16(16'hFFFF);
        rs.stale    = 32'hFFFF_FFFF;
      end
      3: begin
        rs.debounce = 32'(DEBOUNCE_RST);
        rs.settle   = 32'(SETTLE_RST);
        rs.capture  = 32'(CAPTURE_RST);
        rs.stale    = STALE_RST;
      end
      6: begin
        rs.debounce = $urandom;
        rs.settle   = $urandom;
        rs.capture  = $urandom;
        rs.stale    = $urandom;
      end
      default: begin
        rs.debounce = pad16(16'($urandom_range(0, 120)));
        rs.settle   = pad16(16'($urandom_range(0, 3000)));
        rs.capture  = pad16(16'($urandom_range(0, 800)));
        rs.stale    = $urandom_range(0, 4000);
      end
    endcase
    return rs;
  endfunction

  // Result side: check accepted items, stall at random, honor hold-off requests
  initial begin
    int unsigned stall_left;
    status_t     got;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.state      = out_ch.fsm_state;
        got.stale      = out_ch.map_stale;
        got.held       = out_ch.object_held;
        got.frames     = out_ch.frame_count;
        got.bursts     = out_ch.burst_count;
        got.measures   = out_ch.measure_count;
        got.bounces    = out_ch.bounce_count;
        got.ledger_seq = out_ch.ledger_sequence;
        got.entries    = out_ch.ledger_entries;
        sb.check_status(got);
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !steady && $urandom_range(0, 99) < 20) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Event side and run control
  initial begin
    reg_set_t rs;
    sb = new();
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_DEBOUNCE;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_OPENED;
    in_ch.event_time <= '0;
    in_ch.event_arg  <= '0;
    in_ch.entering   <= 1'b0;
    now_ms      = '0;
    events_sent = 0;
    steady      = 1'b0;
    hold_req    = 1'b0;
    pool_span   = 4;
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = 16'($urandom);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_run();

    // Widen the id pool each phase so the ledger fills and then overflows
    for (int phase = 1; phase <= PHASES; phase++) begin
      drain_results();
      rs = pick_regs(phase);
      program_regs(rs);
      pool_span = (phase * 4 > POOL_SIZE) ? POOL_SIZE : phase * 4;
      run_phase(events_sent + PHASE_ITEMS);
    end

    drain_results();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/bsec_pkg.sv
hdl/bsec_if.sv
hdl/bsec_alu.sv
hdl/bsec_ledger.sv
hdl/bag_sensing_event_controller.sv
dv/bsec_sb_pkg.sv
dv/tb.sv
